### src/rrss_pkg.sv
// Shared types and constants for the round-robin slice scheduler.
// Depends on nothing; rrss_ifs and the scheduler top level use it.
package rrss_pkg;

  localparam int MAX_PROCESSES = 8;
  localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int OP_W   = 2;
  localparam int VAL_W  = 12;   // arrival, burst, quantum
  localparam int TIME_W = 16;
  localparam int KIND_W = 2;
  localparam int PIDX_W = 3;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALL_DONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd3;

  // One process table entry as held in the table RAM.
  typedef struct packed {
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } res_t;

endpackage

### src/rrss_ifs.sv
// Command and result channel interfaces of the slice scheduler.
// Depends on rrss_pkg for field widths.
interface rrss_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [rrss_pkg::OP_W-1:0]  operation;
  logic [rrss_pkg::VAL_W-1:0] arrival_time;
  logic [rrss_pkg::VAL_W-1:0] burst_time;

  modport source (output valid, output operation, output arrival_time,
                  output burst_time, input ready);
  modport sink   (input valid, input operation, input arrival_time,
                  input burst_time, output ready);
endinterface

interface rrss_res_if;
  logic                        valid;
  logic                        ready;
  logic [rrss_pkg::KIND_W-1:0] kind;
  logic [rrss_pkg::PIDX_W-1:0] process_index;
  logic [rrss_pkg::TIME_W-1:0] slice_start;
  logic [rrss_pkg::TIME_W-1:0] slice_end;
  logic                        finished;
  logic [rrss_pkg::TIME_W-1:0] turnaround;
  logic [rrss_pkg::TIME_W-1:0] waiting;

  modport source (output valid, output kind, output process_index, output slice_start,
                  output slice_end, output finished, output turnaround, output waiting,
                  input ready);
  modport sink   (input valid, input kind, input process_index, input slice_start,
                  input slice_end, input finished, input turnaround, input waiting,
                  output ready);
endinterface

### src/rrss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/round_robin_slice_scheduler_unit.sv
// Round-robin slice scheduler: top level, sequencer around one table RAM.
// Depends on rrss_pkg, rrss_ifs (channel interfaces) and rrss_ram.
//
// The block keeps a table of up to MAX_PROCESSES processes (arrival, burst,
// remaining service) in a small RAM, a FIFO ready queue of indices and the
// current time. A command transaction is one of clear, append or step. Clear
// and an accepted append give no result; an append to a full table gives one
// result of kind "rejected" through the EMIT state and the output register. A
// step makes one scheduling decision and always gives one result: idle slice,
// run slice or all done. A step walks the process table once through the RAM
// read port (admitting arrivals and finding the earliest pending arrival)
// and, for a run slice, reads and updates the head entry, then walks the table
// again to admit arrivals during the slice. The command channel is not ready
// while a step is in progress, and is ready again in the cycle after the
// result is loaded. The result sits in an output register, so a further
// command is taken while it waits; a later result is held back, and the block
// stalls, until the earlier one has been taken. The time quantum register is
// written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. A quantum of zero
// acts as one.
module round_robin_slice_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rrss_pkg::VAL_W-1:0]  cfg_wdata,
  rrss_cmd_if.sink                    command,
  rrss_res_if.source                  result
);
  import rrss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DECIDE  = 6'b000100,
    S_HEAD_EX = 6'b001000,
    S_FINISH  = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  time_quantum;
  logic [CNT_W-1:0]  process_count;
  logic [CNT_W-1:0]  fifo_count;
  logic [IDX_W-1:0]  fifo_head;
  logic [MAX_PROCESSES-1:0] queued_marks;
  logic [IDX_W-1:0]  ready_fifo [MAX_PROCESSES];
  logic [TIME_W-1:0] current_time;

  // Table walk
  logic [CNT_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  eval_idx;
  logic              eval_vld;
  logic              second_pass;
  logic              pend_any;
  logic [VAL_W-1:0]  next_at;

  // Process being run
  logic [IDX_W-1:0]  cur_idx;
  logic [VAL_W-1:0]  cur_arr;
  logic [VAL_W-1:0]  cur_burst;
  logic [VAL_W-1:0]  rem_new;

  res_t              res;
  res_t              out_q;
  logic              out_valid;
  logic              out_load;

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            ent;

  // Combinational helpers
  logic              cmd_fire;
  logic              issue_vld;
  logic              scan_done;
  logic              admit;
  logic              pend_upd;
  logic [IDX_W-1:0]  fifo_tail;
  logic [VAL_W-1:0]  quantum_eff;
  logic [VAL_W-1:0]  run_len;
  logic [TIME_W-1:0] time_after;
  logic [TIME_W-1:0] idle_end;
  logic [TIME_W-1:0] tat;

  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] offs);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
    if (s >= (CNT_W + 1)'(MAX_PROCESSES)) begin
      s = s - (CNT_W + 1)'(MAX_PROCESSES);
    end
    return IDX_W'(s);
  endfunction

  rrss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCESSES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent      = entry_t'(ram_rdata);
  assign cmd_fire = command.valid && command.ready;
  assign command.ready = (state == S_IDLE);

  // Load the output register from EMIT whenever it is free or being taken
  assign out_load = (state == S_EMIT) && (!out_valid || result.ready);

  // Walk: issue one read a cycle, evaluate the entry once its registered read data returns
  assign issue_vld = (state == S_SCAN) && (scan_idx < process_count);
  assign scan_done = (state == S_SCAN) && !issue_vld && !eval_vld;
  assign fifo_tail = slot_add(fifo_head, fifo_count);

  // Admit an arrived, unfinished, unqueued process; skip the one just run
  assign admit = eval_vld && !(second_pass && (eval_idx == cur_idx)) &&
                 !queued_marks[eval_idx] && (ent.remaining != '0) &&
                 (TIME_W'(ent.arrival) <= current_time) &&
                 (fifo_count < CNT_W'(MAX_PROCESSES));
  assign pend_upd = eval_vld && !second_pass && (ent.remaining != '0) &&
                    (!pend_any || (ent.arrival < next_at));

  // Slice length and new time for the head entry
  assign quantum_eff = (time_quantum == '0) ? VAL_W'(1) : time_quantum;
  assign run_len     = (ent.remaining < quantum_eff) ? ent.remaining : quantum_eff;
  assign time_after  = current_time + TIME_W'(run_len);
  assign idle_end    = (current_time < TIME_W'(next_at)) ? TIME_W'(next_at) : current_time;
  assign tat         = current_time - TIME_W'(cur_arr);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = '{arrival: cur_arr, burst: cur_burst,
                  remaining: ent.remaining - run_len};
    ram_raddr = IDX_W'(scan_idx);
    if (state == S_IDLE) begin
      ram_waddr = IDX_W'(process_count);
      ram_wdata = '{arrival: command.arrival_time, burst: command.burst_time,
                    remaining: command.burst_time};
      ram_we    = cmd_fire && (command.operation == OP_APPEND) &&
                  (process_count < CNT_W'(MAX_PROCESSES));
    end else if (state == S_HEAD_EX) begin
      ram_we    = 1'b1;
      ram_wdata = '{arrival: ent.arrival, burst: ent.burst,
                    remaining: ent.remaining - run_len};
    end else if (state == S_DECIDE) begin
      ram_raddr = ready_fifo[fifo_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      time_quantum  <= VAL_W'(1);
      process_count <= '0;
      fifo_count    <= '0;
      fifo_head     <= '0;
      queued_marks  <= '0;
      current_time  <= '0;
      out_valid     <= 1'b0;
      eval_vld      <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_quantum <= cfg_wdata;
      end
      // Load a waiting result, or drop the held one once taken
      if (out_load) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            case (command.operation)
              OP_CLEAR: begin
                process_count <= '0;
                fifo_count    <= '0;
                fifo_head     <= '0;
                queued_marks  <= '0;
                current_time  <= '0;
              end
              OP_APPEND: begin
                if (process_count < CNT_W'(MAX_PROCESSES)) begin
                  queued_marks[IDX_W'(process_count)] <= 1'b0;
                  process_count <= process_count + CNT_W'(1);
                end else begin
                  res   <= '{kind: KIND_REJECT, default: '0};
                  state <= S_EMIT;
                end
              end
              OP_STEP: begin
                scan_idx    <= '0;
                eval_vld    <= 1'b0;
                second_pass <= 1'b0;
                pend_any    <= 1'b0;
                next_at     <= '0;
                state       <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          eval_vld <= issue_vld;
          eval_idx <= IDX_W'(scan_idx);
          if (issue_vld) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (admit) begin
            ready_fifo[fifo_tail]  <= eval_idx;
            fifo_count             <= fifo_count + CNT_W'(1);
            queued_marks[eval_idx] <= 1'b1;
          end
          if (pend_upd) begin
            pend_any <= 1'b1;
            next_at  <= ent.arrival;
          end
          if (scan_done) begin
            state <= second_pass ? S_FINISH : S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (fifo_count == '0) begin
            // Nothing ready: idle up to the earliest pending arrival, or all done
            if (!pend_any) begin
              res <= '{kind: KIND_ALL_DONE, default: '0};
            end else begin
              res <= '{kind: KIND_IDLE, slice_start: current_time,
                       slice_end: idle_end, default: '0};
              current_time <= idle_end;
            end
            state <= S_EMIT;
          end else begin
            // Pop the head; its entry is read this cycle
            cur_idx    <= ready_fifo[fifo_head];
            fifo_head  <= slot_add(fifo_head, CNT_W'(1));
            fifo_count <= fifo_count - CNT_W'(1);
            queued_marks[ready_fifo[fifo_head]] <= 1'b0;
            state      <= S_HEAD_EX;
          end
        end

        S_HEAD_EX: begin
          cur_arr      <= ent.arrival;
          cur_burst    <= ent.burst;
          rem_new      <= ent.remaining - run_len;
          current_time <= time_after;
          res          <= '{kind: KIND_RUN, process_index: PIDX_W'(cur_idx),
                            slice_start: current_time, slice_end: time_after,
                            default: '0};
          // Second walk admits what arrived during the slice
          scan_idx    <= '0;
          eval_vld    <= 1'b0;
          second_pass <= 1'b1;
          state       <= S_SCAN;
        end

        S_FINISH: begin
          if (rem_new != '0) begin
            if (fifo_count < CNT_W'(MAX_PROCESSES)) begin
              ready_fifo[fifo_tail] <= cur_idx;
              fifo_count            <= fifo_count + CNT_W'(1);
              queued_marks[cur_idx] <= 1'b1;
            end
          end else begin
            res <= '{kind: res.kind, process_index: res.process_index,
                     slice_start: res.slice_start, slice_end: res.slice_end,
                     finished: 1'b1, turnaround: tat,
                     waiting: tat - TIME_W'(cur_burst)};
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          // Hold until the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.kind          = out_q.kind;
  assign result.process_index = out_q.process_index;
  assign result.slice_start   = out_q.slice_start;
  assign result.slice_end     = out_q.slice_end;
  assign result.finished      = out_q.finished;
  assign result.turnaround    = out_q.turnaround;
  assign result.waiting       = out_q.waiting;

  // Queue occupancy never exceeds the table
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    (fifo_count <= CNT_W'(MAX_PROCESSES)) && (process_count <= CNT_W'(MAX_PROCESSES)))
    else $error("ready queue or table over capacity");

  // Every queued index carries exactly one mark
  a_marks_match: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(queued_marks)) == fifo_count)
    else $error("queued marks disagree with queue occupancy");

  // A process taken from the queue still has service left
  a_head_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_HEAD_EX) |-> (ent.remaining != '0))
    else $error("head of ready queue has no remaining service");

  // A walk always ends in a decision or in the final requeue step
  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> ((state == S_DECIDE) || (state == S_FINISH)))
    else $error("table walk did not hand over");

endmodule
